### src/qcfe_pkg.sv
// Package for the quartic curve fit and evaluate block: item types, coefficient
// bundle, register indexes, coefficient unit states and saturation helpers.
// No dependencies.
package qcfe_pkg;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] sample_point;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    CFG_START_POSITION = 3'd0,
    CFG_START_VELOCITY = 3'd1,
    CFG_START_ACCEL    = 3'd2,
    CFG_END_VELOCITY   = 3'd3,
    CFG_END_ACCEL      = 3'd4,
    CFG_CURVE_LENGTH   = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    CS_IDLE, CS_MUL0, CS_MUL1, CS_MUL2, CS_MUL3, CS_MUL4,
    CS_PREP0, CS_PREP1, CS_DIV_START, CS_DIV_WAIT, CS_PACK, CS_SCALE
  } coef_state_e;

  localparam logic [30:0] LEN_RESET = 31'd65536;
  localparam int unsigned DIV_BITS = 128;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [69:0] S70_MAX = 70'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [69:0] S70_MIN = -S70_MAX - 70'sd1;

  typedef struct packed {
    logic signed [63:0] v;
    logic               ov;
  } sat_t;

  // Evaluated coefficients and their scaled forms, plus the coefficient
  // overflow flag that applies to each derivative order.
  typedef struct packed {
    logic signed [63:0] c0;
    logic signed [63:0] c1;
    logic signed [63:0] c2;
    logic signed [63:0] c2x2;
    logic signed [63:0] c3;
    logic signed [63:0] c3x3;
    logic signed [63:0] c3x6;
    logic signed [63:0] c4;
    logic signed [63:0] c4x4;
    logic signed [63:0] c4x12;
    logic signed [63:0] c4x24;
    logic [4:0]         ord_ov;
  } coef_t;

  // State of one item between Horner steps.
  typedef struct packed {
    logic [2:0]         ord;
    logic signed [31:0] s;
    logic [2:0]         skip;
    logic [1:0]         t;
    logic signed [63:0] acc;
    logic               ov;
  } eval_t;

  function automatic sat_t sat70(input logic signed [69:0] x);
    sat_t r;
    r.ov = 1'b0;
    if (x > S70_MAX) begin
      r.v  = S64_MAX;
      r.ov = 1'b1;
    end else if (x < S70_MIN) begin
      r.v  = S64_MIN;
      r.ov = 1'b1;
    end else begin
      r.v = x[63:0];
    end
    return r;
  endfunction

  // Signed value from sign and magnitude, clamped to 64 bits.
  function automatic sat_t pack128(input logic neg, input logic [127:0] mag);
    sat_t r;
    r.ov = 1'b0;
    if (neg) begin
      if (mag > 128'h8000_0000_0000_0000) begin
        r.v  = S64_MIN;
        r.ov = 1'b1;
      end else begin
        r.v = $signed(~mag[63:0] + 64'd1);
      end
    end else begin
      if (mag > 128'h7FFF_FFFF_FFFF_FFFF) begin
        r.v  = S64_MAX;
        r.ov = 1'b1;
      end else begin
        r.v = $signed(mag[63:0]);
      end
    end
    return r;
  endfunction

  // Coefficient added at Horner step t for derivative order ord.
  function automatic logic signed [63:0] add_sel(input coef_t c, input logic [2:0] ord,
                                                 input logic [1:0] t);
    logic signed [63:0] r;
    r = '0;
    unique case (ord)
      3'd0: begin
        unique case (t)
          2'd0: r = c.c3;
          2'd1: r = c.c2;
          2'd2: r = c.c1;
          default: r = c.c0;
        endcase
      end
      3'd1: begin
        unique case (t)
          2'd0: r = c.c3x3;
          2'd1: r = c.c2x2;
          default: r = c.c1;
        endcase
      end
      3'd2: r = (t == 2'd0) ? c.c3x6 : c.c2x2;
      3'd3: r = c.c3x6;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### src/qcfe_div.sv
// Restoring divider, one quotient bit per cycle, 128-bit dividend and divisor.
// Depends on qcfe_pkg.
module qcfe_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] num_i,
  input  logic [127:0] den_i,
  output logic         done_o,
  output logic [127:0] quot_o
);

  logic         busy_q;
  logic [6:0]   cnt_q;
  logic [127:0] n_q, r_q, q_q, den_q;
  logic [127:0] r_shift;
  logic         fits;

  assign r_shift = {r_q[126:0], n_q[127]};
  assign fits    = (r_shift >= den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 7'd1;
      if (cnt_q == 7'(qcfe_pkg::DIV_BITS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      den_q <= den_i;
      r_q   <= '0;
      q_q   <= '0;
    end else if (busy_q) begin
      n_q <= {n_q[126:0], 1'b0};
      r_q <= fits ? (r_shift - den_q) : r_shift;
      q_q <= {q_q[126:0], fits};
    end
  end

  assign done_o = !busy_q;
  assign quot_o = q_q;

endmodule

### src/qcfe_coef.sv
// Configuration registers and the sequencer that fits the quartic coefficients.
// Depends on qcfe_pkg and qcfe_div.
module qcfe_coef (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output logic                busy_o,
  output qcfe_pkg::coef_t     coef_o
);

  qcfe_pkg::coef_state_e state_q, state_d;

  logic signed [31:0] x0_q, v0_q, a0_q, v1_q, a1_q;
  logic [30:0]        len_q;
  logic [30:0]        len_w;

  logic signed [33:0] op_a;
  logic signed [31:0] op_b;
  logic signed [65:0] mul_p;

  logic signed [63:0] a0l_q, b1l_q;
  logic [61:0]        l2_q, t_q, u_q;
  logic signed [67:0] n3_q, n4_q;
  logic [63:0]        d3_q;
  logic [94:0]        d4_q;
  logic               neg3_q, neg4_q;
  logic [127:0]       num3_q, den3_q, num4_q, den4_q;
  logic signed [65:0] b0;
  logic [67:0]        mag3, mag4;
  logic               div_start, done3, done4;
  logic [127:0]       q3, q4;
  qcfe_pkg::sat_t     c3_q, c4_q;
  qcfe_pkg::sat_t     c3x3_q, c3x6_q, c4x4_q, c4x12_q, c4x24_q;
  logic [4:0]         ord_ov;
  qcfe_pkg::sat_t     p3, p4;

  assign len_w = (len_q == '0) ? 31'd1 : len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x0_q  <= '0;
      v0_q  <= '0;
      a0_q  <= '0;
      v1_q  <= '0;
      a1_q  <= '0;
      len_q <= qcfe_pkg::LEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        qcfe_pkg::CFG_START_POSITION: x0_q  <= cfg_data_i;
        qcfe_pkg::CFG_START_VELOCITY: v0_q  <= cfg_data_i;
        qcfe_pkg::CFG_START_ACCEL:    a0_q  <= cfg_data_i;
        qcfe_pkg::CFG_END_VELOCITY:   v1_q  <= cfg_data_i;
        qcfe_pkg::CFG_END_ACCEL:      a1_q  <= cfg_data_i;
        qcfe_pkg::CFG_CURVE_LENGTH:   len_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qcfe_pkg::CS_MUL0;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    unique case (state_q)
      qcfe_pkg::CS_IDLE:      state_d = qcfe_pkg::CS_IDLE;
      qcfe_pkg::CS_MUL0:      state_d = qcfe_pkg::CS_MUL1;
      qcfe_pkg::CS_MUL1:      state_d = qcfe_pkg::CS_MUL2;
      qcfe_pkg::CS_MUL2:      state_d = qcfe_pkg::CS_MUL3;
      qcfe_pkg::CS_MUL3:      state_d = qcfe_pkg::CS_MUL4;
      qcfe_pkg::CS_MUL4:      state_d = qcfe_pkg::CS_PREP0;
      qcfe_pkg::CS_PREP0:     state_d = qcfe_pkg::CS_PREP1;
      qcfe_pkg::CS_PREP1:     state_d = qcfe_pkg::CS_DIV_START;
      qcfe_pkg::CS_DIV_START: begin
        div_start = 1'b1;
        state_d   = qcfe_pkg::CS_DIV_WAIT;
      end
      qcfe_pkg::CS_DIV_WAIT:  state_d = (done3 && done4) ? qcfe_pkg::CS_PACK
                                                         : qcfe_pkg::CS_DIV_WAIT;
      qcfe_pkg::CS_PACK:      state_d = qcfe_pkg::CS_SCALE;
      qcfe_pkg::CS_SCALE:     state_d = qcfe_pkg::CS_IDLE;
      default:                state_d = qcfe_pkg::CS_IDLE;
    endcase
    if (cfg_we_i) begin
      state_d   = qcfe_pkg::CS_MUL0;
      div_start = 1'b0;
    end
  end

  always_comb begin
    op_a = 34'(a0_q);
    op_b = $signed({1'b0, len_w});
    unique case (state_q)
      qcfe_pkg::CS_MUL1: op_a = 34'(a1_q) - 34'(a0_q);
      qcfe_pkg::CS_MUL2: op_a = $signed({3'b0, len_w});
      qcfe_pkg::CS_MUL3: op_a = $signed({3'b0, l2_q[30:0]});
      qcfe_pkg::CS_MUL4: op_a = $signed({3'b0, l2_q[61:31]});
      default: op_a = 34'(a0_q);
    endcase
  end

  assign mul_p = op_a * op_b;

  assign b0   = (66'(v1_q) <<< 16) - 66'(a0l_q) - (66'(v0_q) <<< 16);
  assign mag3 = n3_q[67] ? 68'(-n3_q) : 68'(n3_q);
  assign mag4 = n4_q[67] ? 68'(-n4_q) : 68'(n4_q);
  assign p3   = qcfe_pkg::pack128(neg3_q, q3);
  assign p4   = qcfe_pkg::pack128(neg4_q, q4);

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      qcfe_pkg::CS_MUL0: a0l_q <= mul_p[63:0];
      qcfe_pkg::CS_MUL1: b1l_q <= mul_p[63:0];
      qcfe_pkg::CS_MUL2: l2_q  <= mul_p[61:0];
      qcfe_pkg::CS_MUL3: t_q   <= mul_p[61:0];
      qcfe_pkg::CS_MUL4: u_q   <= mul_p[61:0];
      qcfe_pkg::CS_PREP0: begin
        n3_q <= 68'(b0) + 68'(b0) + 68'(b0) - 68'(b1l_q);
        n4_q <= 68'(b1l_q) - 68'(b0) - 68'(b0);
        d3_q <= 64'(l2_q) + 64'({l2_q, 1'b0});
        d4_q <= (95'(u_q) << 33) + (95'(t_q) << 2);
      end
      qcfe_pkg::CS_PREP1: begin
        neg3_q <= n3_q[67];
        neg4_q <= n4_q[67];
        num3_q <= (128'(mag3) << 33) + 128'(d3_q);
        den3_q <= 128'(d3_q) << 1;
        num4_q <= (128'(mag4) << 49) + 128'(d4_q);
        den4_q <= 128'(d4_q) << 1;
      end
      qcfe_pkg::CS_PACK: begin
        c3_q <= p3;
        c4_q <= p4;
      end
      qcfe_pkg::CS_SCALE: begin
        c3x3_q   <= qcfe_pkg::sat70(70'(c3_q.v) * 70'sd3);
        c3x6_q   <= qcfe_pkg::sat70(70'(c3_q.v) * 70'sd6);
        c4x4_q   <= qcfe_pkg::sat70(70'(c4_q.v) * 70'sd4);
        c4x12_q  <= qcfe_pkg::sat70(70'(c4_q.v) * 70'sd12);
        c4x24_q  <= qcfe_pkg::sat70(70'(c4_q.v) * 70'sd24);
      end
      default: ;
    endcase
  end

  always_comb begin
    ord_ov[0] = c4_q.ov | c3_q.ov;
    ord_ov[1] = c4_q.ov | c3_q.ov | c4x4_q.ov | c3x3_q.ov;
    ord_ov[2] = c4_q.ov | c3_q.ov | c4x12_q.ov | c3x6_q.ov;
    ord_ov[3] = c4_q.ov | c3_q.ov | c4x24_q.ov | c3x6_q.ov;
    ord_ov[4] = c4_q.ov | c4x24_q.ov;
  end

  qcfe_div u_div3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num3_q),
    .den_i   (den3_q),
    .done_o  (done3),
    .quot_o  (q3)
  );

  qcfe_div u_div4 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num4_q),
    .den_i   (den4_q),
    .done_o  (done4),
    .quot_o  (q4)
  );

  assign busy_o = (state_q != qcfe_pkg::CS_IDLE);

  always_comb begin
    coef_o.c0     = 64'(x0_q) <<< 16;
    coef_o.c1     = 64'(v0_q) <<< 16;
    coef_o.c2     = 64'(a0_q) <<< 15;
    coef_o.c2x2   = 64'(a0_q) <<< 16;
    coef_o.c3     = c3_q.v;
    coef_o.c3x3   = c3x3_q.v;
    coef_o.c3x6   = c3x6_q.v;
    coef_o.c4     = c4_q.v;
    coef_o.c4x4   = c4x4_q.v;
    coef_o.c4x12  = c4x12_q.v;
    coef_o.c4x24  = c4x24_q.v;
    coef_o.ord_ov = ord_ov;
  end

endmodule

### src/qcfe_step.sv
// One Horner step in three register stages: partial products, rounding, add.
// Depends on qcfe_pkg.
module qcfe_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  qcfe_pkg::coef_t   coef_i,
  input  logic              valid_i,
  input  qcfe_pkg::eval_t   item_i,
  output logic              valid_o,
  output qcfe_pkg::eval_t   item_o
);

  logic            va_q, vb_q, vc_q;
  qcfe_pkg::eval_t a_q, b_q, c_q;
  logic [63:0]     plo_q, phi_q;
  logic            neg_q;
  logic [63:0]     ma;
  logic [31:0]     ms;
  logic [95:0]     m;
  qcfe_pkg::sat_t  prod_d, prod_q;
  qcfe_pkg::sat_t  sum;
  qcfe_pkg::eval_t c_d;

  assign ma = item_i.acc[63] ? 64'(-item_i.acc) : 64'(item_i.acc);
  assign ms = item_i.s[31] ? 32'(-item_i.s) : 32'(item_i.s);

  assign m      = {phi_q, 32'b0} + 96'(plo_q) + 96'(1 << 15);
  assign prod_d = qcfe_pkg::pack128(neg_q, 128'(m[95:16]));

  assign sum = qcfe_pkg::sat70(70'(prod_q.v) + 70'(qcfe_pkg::add_sel(coef_i, b_q.ord, b_q.t)));

  always_comb begin
    c_d = b_q;
    if (b_q.skip == 3'd0) begin
      c_d.acc = sum.v;
      c_d.ov  = b_q.ov | prod_q.ov | sum.ov;
      c_d.t   = b_q.t + 2'd1;
    end else begin
      c_d.skip = b_q.skip - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_q    <= item_i;
      plo_q  <= 64'(ma[31:0]) * 64'(ms);
      phi_q  <= 64'(ma[63:32]) * 64'(ms);
      neg_q  <= item_i.acc[63] ^ item_i.s[31];
      b_q    <= a_q;
      prod_q <= prod_d;
      c_q    <= c_d;
    end
  end

  assign valid_o = vc_q;
  assign item_o  = c_q;

endmodule

### src/quartic_curve_fit_and_evaluate_top.sv
// Top level of the quartic curve fit and evaluate block: input stage, four
// Horner steps, output rounding. Depends on qcfe_pkg, qcfe_coef and qcfe_step.
//
// The block takes one item per clock cycle while neither the output stall nor
// the coefficient unit holds input back; each item passes an input register,
// three stages for each of four Horner steps, and the rounding output register.
// After reset and after every configuration write the coefficient unit refits
// the quartic with restoring dividers; input stays stalled until it is done.
module quartic_curve_fit_and_evaluate_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  qcfe_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output qcfe_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  logic             busy, adv, accept;
  qcfe_pkg::coef_t  coef;
  logic             v0_q;
  qcfe_pkg::eval_t  s0_q, s0_d;
  logic [4:0]       sv;
  qcfe_pkg::eval_t  si [5];
  logic             out_valid_q;
  qcfe_pkg::out_item_t out_q, out_d;
  logic [63:0]      fmag;
  logic [48:0]      frnd;

  qcfe_coef u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (busy),
    .coef_o      (coef)
  );

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv || busy;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s0_d.ord  = in_item_i.func;
    s0_d.s    = in_item_i.sample_point;
    s0_d.skip = in_item_i.func;
    s0_d.t    = 2'd0;
    s0_d.ov   = 1'b0;
    unique case (in_item_i.func)
      3'd0: s0_d.acc = coef.c4;
      3'd1: s0_d.acc = coef.c4x4;
      3'd2: s0_d.acc = coef.c4x12;
      default: s0_d.acc = coef.c4x24;
    endcase
    if (in_item_i.func <= 3'd4) begin
      s0_d.ov = coef.ord_ov[in_item_i.func];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q <= s0_d;
    end
  end

  assign sv[0] = v0_q;
  assign si[0] = s0_q;

  for (genvar g = 0; g < 4; g++) begin : g_step
    qcfe_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .coef_i  (coef),
      .valid_i (sv[g]),
      .item_i  (si[g]),
      .valid_o (sv[g+1]),
      .item_o  (si[g+1])
    );
  end

  assign fmag = si[4].acc[63] ? 64'(-si[4].acc) : 64'(si[4].acc);
  assign frnd = 49'((65'(fmag) + 65'(1 << 15)) >> 16);

  always_comb begin
    out_d.overflow = si[4].ov;
    if (si[4].acc[63]) begin
      if (frnd > 49'h8000_0000) begin
        out_d.value    = 32'sh8000_0000;
        out_d.overflow = 1'b1;
      end else begin
        out_d.value = $signed(~frnd[31:0] + 32'd1);
      end
    end else begin
      if (frnd > 49'h7FFF_FFFF) begin
        out_d.value    = 32'sh7FFF_FFFF;
        out_d.overflow = 1'b1;
      end else begin
        out_d.value = $signed(frnd[31:0]);
      end
    end
    if (si[4].ord > 3'd4) begin
      out_d.value    = '0;
      out_d.overflow = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sv[4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### verif/quartic_curve_fit_and_evaluate_top_tb.sv
// Self-checking testbench for quartic_curve_fit_and_evaluate_top: a queue-fed driver,
// a stalling output monitor and a bit-exact fixed-point predictor of the fitted quartic.
// Depends on qcfe_pkg and the block's RTL.
`timescale 1ns / 100ps

module quartic_curve_fit_and_evaluate_top_tb;

  localparam int MAX_CYCLES = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  qcfe_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  qcfe_pkg::out_item_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  quartic_curve_fit_and_evaluate_top u_dut (.*);

  always #5 clk_i = ~clk_i;

  logic signed [31:0] x0_r, v0_r, a0_r, v1_r, a1_r;
  logic [30:0] len_r;

  qcfe_pkg::in_item_t pending_q[$];
  qcfe_pkg::out_item_t expected_q[$];
  int mismatches = 0;
  int cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit in_acc = 1'b0;
  bit out_acc = 1'b0;

  function automatic logic signed [63:0] clamp_mag(input bit neg, input logic [127:0] m,
                                                   inout bit ov);
    if (neg) begin
      if (m > 128'h8000_0000_0000_0000) begin
        ov = 1'b1;
        return qcfe_pkg::S64_MIN;
      end
      return -$signed(m[63:0]);
    end
    if (m > 128'h7FFF_FFFF_FFFF_FFFF) begin
      ov = 1'b1;
      return qcfe_pkg::S64_MAX;
    end
    return m[63:0];
  endfunction

  // Rounds |a*b| >> sh to nearest, ties away, and clamps to 64 bits.
  function automatic logic signed [63:0] mul_round(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input int sh, inout bit ov);
    logic [127:0] m;
    logic [63:0] ma, mb;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    m = 128'(ma) * 128'(mb);
    if (sh > 0) m = (m + (128'd1 << (sh - 1))) >> sh;
    return clamp_mag(a[63] != b[63], m, ov);
  endfunction

  function automatic logic signed [63:0] add_clamp(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   inout bit ov);
    logic signed [64:0] r;
    r = 65'(a) + 65'(b);
    if (r > 65'(qcfe_pkg::S64_MAX)) begin
      ov = 1'b1;
      return qcfe_pkg::S64_MAX;
    end
    if (r < 65'(qcfe_pkg::S64_MIN)) begin
      ov = 1'b1;
      return qcfe_pkg::S64_MIN;
    end
    return r[63:0];
  endfunction

  function automatic logic signed [63:0] round_div(input logic signed [127:0] num, input int sh,
                                                   input logic [127:0] den, inout bit ov);
    logic [127:0] mag, q;
    bit neg;
    neg = num[127];
    mag = neg ? -num : num;
    q = ((mag << (sh + 1)) + den) / (den << 1);
    return clamp_mag(neg, q, ov);
  endfunction

  function automatic qcfe_pkg::out_item_t predict_derivative(input qcfe_pkg::in_item_t it);
    qcfe_pkg::out_item_t r;
    logic signed [63:0] s, len, c0, c1, c2, c3, c4, b0, b1l, acc;
    logic [127:0] l2;
    bit ov, ov3, ov4;
    ov = 0; ov3 = 0; ov4 = 0;
    r = '0;
    if (it.func > 3'd4) return r;
    s = it.sample_point;
    len = (len_r == 0) ? 64'sd1 : 64'(len_r);
    c0 = 64'(x0_r) * 65536;
    c1 = 64'(v0_r) * 65536;
    c2 = 64'(a0_r) * 32768;
    b0 = 64'(v1_r) * 65536 - 64'(a0_r) * len - 64'(v0_r) * 65536;
    b1l = (64'(a1_r) - 64'(a0_r)) * len;
    l2 = 128'(len) * 128'(len);
    c3 = round_div(128'(b0) * 3 - 128'(b1l), 32, l2 * 3, ov3);
    c4 = round_div(128'(b1l) - 128'(b0) * 2, 48, 128'(l2[63:0] * 128'(len)) << 2, ov4);
    ov = ov4 || (it.func <= 3 && ov3);
    case (it.func)
      3'd0: begin
        acc = c4;
        acc = add_clamp(mul_round(acc, s, 16, ov), c3, ov);
        acc = add_clamp(mul_round(acc, s, 16, ov), c2, ov);
        acc = add_clamp(mul_round(acc, s, 16, ov), c1, ov);
        acc = add_clamp(mul_round(acc, s, 16, ov), c0, ov);
      end
      3'd1: begin
        acc = mul_round(c4, 4, 0, ov);
        acc = add_clamp(mul_round(acc, s, 16, ov), mul_round(c3, 3, 0, ov), ov);
        acc = add_clamp(mul_round(acc, s, 16, ov), mul_round(c2, 2, 0, ov), ov);
        acc = add_clamp(mul_round(acc, s, 16, ov), c1, ov);
      end
      3'd2: begin
        acc = mul_round(c4, 12, 0, ov);
        acc = add_clamp(mul_round(acc, s, 16, ov), mul_round(c3, 6, 0, ov), ov);
        acc = add_clamp(mul_round(acc, s, 16, ov), mul_round(c2, 2, 0, ov), ov);
      end
      3'd3: begin
        acc = mul_round(c4, 24, 0, ov);
        acc = add_clamp(mul_round(acc, s, 16, ov), mul_round(c3, 6, 0, ov), ov);
      end
      default: acc = mul_round(c4, 24, 0, ov);
    endcase
    acc = mul_round(acc, 1, 16, ov);
    if (acc > 64'sh7FFF_FFFF) begin
      acc = 64'sh7FFF_FFFF;
      ov = 1'b1;
    end
    if (acc < -64'sh8000_0000) begin
      acc = -64'sh8000_0000;
      ov = 1'b1;
    end
    r.value = acc[31:0];
    r.overflow = ov;
    return r;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_acc)) begin
      if (in_acc) begin
        in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 4) == 0) in_gap = 0;
      end
      if (in_gap > 0 || pending_q.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_valid_i <= 1'b0;
      end else begin
        in_item_i <= pending_q.pop_front();
        in_valid_i <= 1'b1;
      end
    end
    if (rst_ni) begin
      if (out_acc) out_gap = $urandom_range(0, 2) == 0 ? $urandom_range(0, 19) : 0;
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    in_acc = rst_ni && in_valid_i && !in_stall_o;
    out_acc = rst_ni && out_valid_o && !out_stall_i;
    if (in_acc) expected_q.push_back(predict_derivative(in_item_i));
    if (out_acc) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%h ov=%b",
                                       out_item_o.value, out_item_o.overflow);
      end else if (out_item_o !== expected_q[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value=%h ov=%b, got value=%h ov=%b",
                   expected_q[0].value, expected_q[0].overflow,
                   out_item_o.value, out_item_o.overflow);
        void'(expected_q.pop_front());
      end else begin
        void'(expected_q.pop_front());
      end
    end
    if (cycles > MAX_CYCLES) begin
      $display("quartic_curve_fit_and_evaluate_top_tb: FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input qcfe_pkg::cfg_idx_e idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      qcfe_pkg::CFG_START_POSITION: x0_r = data;
      qcfe_pkg::CFG_START_VELOCITY: v0_r = data;
      qcfe_pkg::CFG_START_ACCEL:    a0_r = data;
      qcfe_pkg::CFG_END_VELOCITY:   v1_r = data;
      qcfe_pkg::CFG_END_ACCEL:      a1_r = data;
      default:                      len_r = data[30:0];
    endcase
  endtask

  function automatic logic [31:0] pick_value(input int mode);
    case (mode)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 65536 * 8))
                                     : -32'($urandom_range(0, 65536 * 8));
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_items(input int n, input int spread);
    qcfe_pkg::in_item_t it;
    for (int k = 0; k < n; k++) begin
      it.func = 3'($urandom_range(0, 7));
      it.sample_point = (spread == 0) ? pick_value(2) : pick_value($urandom_range(0, 3));
      pending_q.push_back(it);
    end
  endtask

  initial begin
    qcfe_pkg::in_item_t it;
    x0_r = 0; v0_r = 0; a0_r = 0; v1_r = 0; a1_r = 0;
    len_r = qcfe_pkg::LEN_RESET;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int f = 0; f < 8; f++) begin
      it.func = 3'(f);
      it.sample_point = 32'sd65536;
      pending_q.push_back(it);
    end
    wait_drained();
    write_reg(qcfe_pkg::CFG_START_POSITION, 32'h0003_0000);
    write_reg(qcfe_pkg::CFG_START_VELOCITY, 32'hFFFF_8000);
    write_reg(qcfe_pkg::CFG_START_ACCEL, 32'h0002_0000);
    write_reg(qcfe_pkg::CFG_END_VELOCITY, 32'h0001_0000);
    write_reg(qcfe_pkg::CFG_END_ACCEL, 32'hFFFE_0000);
    write_reg(qcfe_pkg::CFG_CURVE_LENGTH, 32'h0004_0000);
    for (int f = 0; f < 5; f++) begin
      it.func = 3'(f);
      it.sample_point = 32'h7FFF_FFFF;
      pending_q.push_back(it);
      it.sample_point = 32'h8000_0000;
      pending_q.push_back(it);
      it.sample_point = 32'h0002_0000;
      pending_q.push_back(it);
    end
    wait_drained();
    write_reg(qcfe_pkg::CFG_CURVE_LENGTH, 32'h0000_0000);
    queue_items(6, 1);
    wait_drained();
    for (int phase = 0; phase < 8; phase++) begin
      for (int r = 0; r < 6; r++) begin
        if (phase >= 2 || $urandom_range(0, 1)) begin
          if (r == 5) begin
            case (phase)
              0: write_reg(qcfe_pkg::CFG_CURVE_LENGTH, 32'h7FFF_FFFF);
              1: write_reg(qcfe_pkg::CFG_CURVE_LENGTH, 32'd1);
              default: write_reg(qcfe_pkg::CFG_CURVE_LENGTH, $urandom_range(0, 1)
                                 ? 32'($urandom_range(16384, 65536 * 16)) : $urandom);
            endcase
          end else begin
            write_reg(qcfe_pkg::cfg_idx_e'(r),
                      phase == 0 ? 32'h7FFF_FFFF : phase == 1 ? 32'h8000_0000
                      : pick_value($urandom_range(2, 3)));
          end
        end
      end
      queue_items(46, phase % 2);
      wait_drained();
    end
    if (mismatches == 0) begin
      $display("quartic_curve_fit_and_evaluate_top_tb: PASS");
    end else begin
      $display("quartic_curve_fit_and_evaluate_top_tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
src/qcfe_pkg.sv
src/qcfe_div.sv
src/qcfe_coef.sv
src/qcfe_step.sv
src/quartic_curve_fit_and_evaluate_top.sv
verif/quartic_curve_fit_and_evaluate_top_tb.sv
